FILE: hdl/sfnc_pkg.sv
package sfnc_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_SPW   = $clog2(STACK_DEPTH + 1);

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    localparam int PADDR_W = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_STREAM_LENGTH = 1'b0;
    localparam logic REG_ERROR_LIMIT   = 1'b1;

    localparam logic [31:0] STREAM_LENGTH_RESET = 32'd0;
    localparam logic [7:0]  ERROR_LIMIT_RESET   = 8'd10;

    localparam logic [7:0] INTRODUCER  = 8'h5A;
    localparam logic [7:0] ID_CLASS    = 8'hD3;
    localparam logic [7:0] TYPE_BEGIN  = 8'hA8;
    localparam logic [7:0] TYPE_END    = 8'hA9;
    localparam logic [7:0] CAT_DOC     = 8'hA8;
    localparam logic [7:0] CAT_GROUP_A = 8'hAD;
    localparam logic [7:0] CAT_PAGE    = 8'hAF;
    localparam logic [7:0] CAT_AEG     = 8'hC9;
    localparam logic [7:0] CAT_GROUP_B = 8'hC6;
    localparam logic [7:0] CAT_OBJECT  = 8'hDF;

    localparam logic [15:0] MIN_LENGTH = 16'd6;

    localparam logic [2:0] K_DONE      = 3'd0;
    localparam logic [2:0] K_BAD_INTRO = 3'd1;
    localparam logic [2:0] K_SHORT     = 3'd2;
    localparam logic [2:0] K_OVERRUN   = 3'd3;
    localparam logic [2:0] K_TRUNCATED = 3'd4;
    localparam logic [2:0] K_SUMMARY   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] record_id;
        logic [15:0] record_length;
        logic        nest_mismatch;
        logic [7:0]  open_depth;
        logic [31:0] records_seen;
        logic [7:0]  errors_seen;
        logic [15:0] pages_seen;
        logic [15:0] groups_seen;
        logic [1:0]  document_marks;
        logic        stream_valid;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [31:0] stream_length;
        logic [7:0]  error_limit;
    } t_cfg;

    // Up to two results leave the framer for one byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  r0;
        t_out_item  r1;
    } t_res_set;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [2:0] kind;
    } t_stack_cmd;

    typedef struct packed {
        logic [STACK_SPW-1:0] depth;
        logic                 full;
        logic [2:0]           top;
    } t_stack_stat;

    function automatic logic [2:0] kind_of(input logic [7:0] code);
        logic [2:0] k;
        unique case (code)
            CAT_DOC:     k = 3'd1;
            CAT_GROUP_A: k = 3'd2;
            CAT_PAGE:    k = 3'd3;
            CAT_AEG:     k = 3'd4;
            CAT_GROUP_B: k = 3'd5;
            CAT_OBJECT:  k = 3'd6;
            default:     k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/sfnc_cfg.sv
module sfnc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfnc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sfnc_pkg::t_cfg              o_cfg
);
    import sfnc_pkg::*;

    logic [31:0] r_stream_length;
    logic [7:0]  r_error_limit;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= STREAM_LENGTH_RESET;
            r_error_limit   <= ERROR_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_STREAM_LENGTH: r_stream_length <= pwdata;
                REG_ERROR_LIMIT:   r_error_limit   <= pwdata[7:0];
                default:           r_error_limit   <= r_error_limit;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STREAM_LENGTH: prdata = r_stream_length;
            REG_ERROR_LIMIT:   prdata = {24'h000000, r_error_limit};
            default:           prdata = 32'h00000000;
        endcase
    end

    assign o_cfg.stream_length = r_stream_length;
    assign o_cfg.error_limit   = r_error_limit;

endmodule

FILE: hdl/sfnc_stack.sv
module sfnc_stack (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfnc_pkg::t_stack_cmd   i_cmd,
    output sfnc_pkg::t_stack_stat  o_stat
);
    import sfnc_pkg::*;

    logic [2:0]           mem [STACK_DEPTH];
    logic [STACK_SPW-1:0] r_sp;
    logic [2:0]           r_top;
    logic [2:0]           r_below;
    logic [STACK_SPW-1:0] sp_m1;
    logic [STACK_SPW-1:0] sp_m2;
    logic                 full;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (r_sp == STACK_SPW'(STACK_DEPTH));
    assign do_push = i_cmd.push && !full;
    assign do_pop  = i_cmd.pop && (r_sp != '0);
    assign sp_m1   = r_sp - STACK_SPW'(1);
    assign sp_m2   = r_sp - STACK_SPW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sp <= '0;
        end else if (do_push) begin
            r_sp <= r_sp + STACK_SPW'(1);
        end else if (do_pop) begin
            r_sp <= sp_m1;
        end
    end

    // The top entry lives in r_top; the memory holds the entries below it.
    // The entry under the top is read back every cycle. Pushes and pops
    // come at least seven bytes apart, so r_below is current at each pop.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top <= i_cmd.kind;
        end else if (do_pop) begin
            r_top <= r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push && (r_sp != '0)) begin
            mem[sp_m1[STACK_AW-1:0]] <= r_top;
        end
        r_below <= mem[sp_m2[STACK_AW-1:0]];
    end

    assign o_stat.depth = r_sp;
    assign o_stat.full  = full;
    assign o_stat.top   = (r_sp != '0) ? r_top : 3'd0;

endmodule

FILE: hdl/sfnc_core.sv
module sfnc_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_proc,
    input  sfnc_pkg::t_in_item     i_item,
    input  sfnc_pkg::t_cfg         i_cfg,
    input  sfnc_pkg::t_stack_stat  i_stk,
    output sfnc_pkg::t_stack_cmd   o_stk_cmd,
    output sfnc_pkg::t_res_set     o_res
);
    import sfnc_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_HEAD   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    logic [2:0]  r_phase,   n_phase;
    logic [31:0] r_bp,      n_bp;
    logic [15:0] r_len,     n_len;
    logic [23:0] r_id,      n_id;
    logic [15:0] r_dr,      n_dr;
    logic [31:0] r_records, n_records;
    logic [7:0]  r_errors,  n_errors;
    logic [15:0] r_pages,   n_pages;
    logic [15:0] r_groups,  n_groups;
    logic [1:0]  r_marks,   n_marks;
    logic        r_valid,   n_valid;
    logic        r_halt,    n_halt;

    logic [7:0]  b;
    logic        eos;
    logic [15:0] len_cat;
    logic [31:0] rec_start;
    logic [33:0] rec_end;
    logic        overrun;

    logic [2:0]  fin_kind;
    logic        fin_nest;
    logic        push_req;
    logic        pop_req;
    logic        fin_mis;

    logic        emit_main;
    logic [2:0]  main_kind;
    logic [15:0] main_len;
    logic        do_finish;

    logic [STACK_SPW-1:0] depth_after;
    logic        trunc;
    logic [15:0] trunc_len;
    t_out_item   s1;
    t_out_item   s2;

    assign b   = i_item.data_byte;
    assign eos = i_item.end_of_stream;

    assign len_cat   = {r_len[7:0], b};
    assign rec_start = (r_bp >= 32'd2) ? (r_bp - 32'd2) : 32'd0;
    assign rec_end   = {2'b00, rec_start} + {18'h00000, len_cat} + 34'd1;
    assign overrun   = rec_end > {2'b00, i_cfg.stream_length};

    assign fin_kind = kind_of(r_id[7:0]);
    assign fin_nest = (r_id[23:16] == ID_CLASS) && (fin_kind != 3'd0);
    assign push_req = fin_nest && (r_id[15:8] == TYPE_BEGIN);
    assign pop_req  = fin_nest && (r_id[15:8] == TYPE_END);
    assign fin_mis  = pop_req && (i_stk.top != fin_kind);

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_id      = r_id;
        n_dr      = r_dr;
        n_records = r_records;
        n_errors  = r_errors;
        n_pages   = r_pages;
        n_groups  = r_groups;
        n_marks   = r_marks;
        n_valid   = r_valid;
        n_halt    = r_halt;
        emit_main = 1'b0;
        main_kind = K_DONE;
        main_len  = 16'h0000;
        do_finish = 1'b0;

        if (!r_halt) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_bp < i_cfg.stream_length) begin
                        if (b == INTRODUCER) begin
                            n_phase = PH_LEN_HI;
                        end else begin
                            n_valid   = 1'b0;
                            n_errors  = (r_errors == 8'hFF) ? r_errors : r_errors + 8'd1;
                            emit_main = 1'b1;
                            main_kind = K_BAD_INTRO;
                            if (n_errors > i_cfg.error_limit) begin
                                n_halt = 1'b1;
                            end
                        end
                    end
                end
                PH_LEN_HI: begin
                    n_len   = {8'h00, b};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len    = len_cat;
                    main_len = len_cat;
                    if (len_cat < MIN_LENGTH || overrun) begin
                        n_valid   = 1'b0;
                        n_errors  = (r_errors == 8'hFF) ? r_errors : r_errors + 8'd1;
                        n_phase   = PH_HUNT;
                        emit_main = 1'b1;
                        main_kind = (len_cat < MIN_LENGTH) ? K_SHORT : K_OVERRUN;
                    end else begin
                        n_phase = PH_HEAD;
                        n_dr    = 16'd4;
                    end
                end
                PH_HEAD: begin
                    // Three id bytes, then the flag byte, which is not kept.
                    if (r_dr != 16'd1) begin
                        n_id = {r_id[15:0], b};
                        n_dr = r_dr - 16'd1;
                    end else begin
                        n_dr = r_len - MIN_LENGTH;
                        if (r_len == MIN_LENGTH) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                default: begin
                    if (r_dr <= 16'd1) begin
                        n_dr      = 16'h0000;
                        do_finish = 1'b1;
                    end else begin
                        n_dr = r_dr - 16'd1;
                    end
                end
            endcase
        end

        if (do_finish) begin
            n_phase   = PH_HUNT;
            n_records = (r_records == 32'hFFFFFFFF) ? r_records : r_records + 32'd1;
            if (push_req) begin
                if (r_id[7:0] == CAT_DOC) begin
                    n_marks[0] = 1'b1;
                end
                if (r_id[7:0] == CAT_PAGE && r_pages != 16'hFFFF) begin
                    n_pages = r_pages + 16'd1;
                end
                if (r_id[7:0] == CAT_AEG && r_groups != 16'hFFFF) begin
                    n_groups = r_groups + 16'd1;
                end
            end
            if (pop_req && r_id[7:0] == CAT_DOC) begin
                n_marks[1] = 1'b1;
            end
            if (fin_mis) begin
                n_valid = 1'b0;
            end
            emit_main = 1'b1;
            main_kind = K_DONE;
            main_len  = r_len;
        end
    end

    assign n_bp = (r_bp == 32'hFFFFFFFF) ? r_bp : r_bp + 32'd1;

    assign o_stk_cmd.push  = i_proc && do_finish && push_req;
    assign o_stk_cmd.pop   = i_proc && do_finish && pop_req;
    assign o_stk_cmd.clear = i_proc && eos;
    assign o_stk_cmd.kind  = fin_kind;

    always_comb begin
        depth_after = i_stk.depth;
        if (do_finish && push_req && !i_stk.full) begin
            depth_after = i_stk.depth + STACK_SPW'(1);
        end else if (do_finish && pop_req && i_stk.depth != '0) begin
            depth_after = i_stk.depth - STACK_SPW'(1);
        end
    end

    assign trunc     = (n_phase != PH_HUNT);
    assign trunc_len = (n_phase == PH_HEAD || n_phase == PH_DATA) ? n_len : 16'h0000;

    always_comb begin
        s1.kind           = K_DONE;
        s1.record_id      = 24'h000000;
        s1.record_length  = 16'h0000;
        s1.nest_mismatch  = 1'b0;
        s1.open_depth     = 8'(depth_after);
        s1.records_seen   = n_records;
        s1.errors_seen    = n_errors;
        s1.pages_seen     = n_pages;
        s1.groups_seen    = n_groups;
        s1.document_marks = n_marks;
        s1.stream_valid   = n_valid;
        s1.last_result    = 1'b0;

        // A truncated record clears validity before both end-of-stream results.
        s2              = s1;
        s2.stream_valid = n_valid && !trunc;

        o_res.cnt = 2'd0;
        o_res.r0  = s1;
        o_res.r1  = s1;
        if (emit_main) begin
            o_res.r0.kind             = main_kind;
            o_res.r0.record_length    = main_len;
            o_res.r0.last_result      = !eos;
            if (main_kind == K_DONE) begin
                o_res.r0.record_id     = r_id;
                o_res.r0.nest_mismatch = fin_mis;
            end
            o_res.r1.kind        = K_SUMMARY;
            o_res.r1.last_result = 1'b1;
            o_res.cnt            = eos ? 2'd2 : 2'd1;
        end else if (eos) begin
            if (trunc) begin
                o_res.r0               = s2;
                o_res.r0.kind          = K_TRUNCATED;
                o_res.r0.record_length = trunc_len;
                o_res.r1               = s2;
                o_res.r1.kind          = K_SUMMARY;
                o_res.r1.last_result   = 1'b1;
                o_res.cnt              = 2'd2;
            end else begin
                o_res.r0.kind        = K_SUMMARY;
                o_res.r0.last_result = 1'b1;
                o_res.cnt            = 2'd1;
            end
        end
        if (!i_proc) begin
            o_res.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_proc && eos)) begin
            r_phase   <= PH_HUNT;
            r_bp      <= 32'd0;
            r_len     <= 16'h0000;
            r_id      <= 24'h000000;
            r_dr      <= 16'h0000;
            r_records <= 32'd0;
            r_errors  <= 8'd0;
            r_pages   <= 16'd0;
            r_groups  <= 16'd0;
            r_marks   <= 2'b00;
            r_valid   <= 1'b1;
            r_halt    <= 1'b0;
        end else if (i_proc) begin
            r_phase   <= n_phase;
            r_bp      <= n_bp;
            r_len     <= n_len;
            r_id      <= n_id;
            r_dr      <= n_dr;
            r_records <= n_records;
            r_errors  <= n_errors;
            r_pages   <= n_pages;
            r_groups  <= n_groups;
            r_marks   <= n_marks;
            r_valid   <= n_valid;
            r_halt    <= n_halt;
        end
    end

`ifndef SYNTHESIS
    a_halt_only_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (r_phase == PH_HUNT))
        else $error("halted outside of introducer hunt");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD) |-> (r_dr != 16'd0 && r_dr <= 16'd4))
        else $error("header byte count out of range");

    a_pair_ends_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.cnt == 2'd2) |-> (o_res.r1.kind == K_SUMMARY && o_res.r1.last_result
                                 && !o_res.r0.last_result))
        else $error("result pair not closed by a summary");
`endif

endmodule

FILE: hdl/sfnc_ofifo.sv
module sfnc_ofifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfnc_pkg::t_res_set  i_res,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output sfnc_pkg::t_out_item o_data
);
    import sfnc_pkg::*;

    t_out_item             fifo [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wr;
    logic [OFIFO_AW-1:0]   r_rd;
    logic [OFIFO_CW-1:0]   r_count;
    logic [OFIFO_AW-1:0]   wr_p1;
    logic                  pop;

    assign wr_p1   = r_wr + OFIFO_AW'(1);
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= OFIFO_CW'(OFIFO_DEPTH - 2));
    assign o_data  = fifo[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_res.cnt != 2'd0) begin
            fifo[r_wr] <= i_res.r0;
        end
        if (i_res.cnt == 2'd2) begin
            fifo[wr_p1] <= i_res.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + OFIFO_AW'(i_res.cnt);
            r_rd    <= r_rd + OFIFO_AW'(pop);
            r_count <= r_count + OFIFO_CW'(i_res.cnt) - OFIFO_CW'(pop);
        end
    end

endmodule

FILE: hdl/structured_field_nesting_checker.sv
// Path: an accepted byte is held in r_in, and its results go into the result queue.
// Throughput: one byte per cycle while the queue has room for two more results;
// a byte yields up to two results, which leave through a four-entry result queue
// at one per cycle while the output side does not stall.
// Reset: synchronous, active low; registers return to their defaults and all
// framing state, counters and the kind stack are cleared.
module structured_field_nesting_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  sfnc_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sfnc_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfnc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sfnc_pkg::*;

    t_in_item    r_in;
    logic        r_in_valid;
    logic        room;
    logic        proc;
    logic        accept;
    t_cfg        cfg;
    t_stack_cmd  stk_cmd;
    t_stack_stat stk_stat;
    t_res_set    res;

    // The held byte is worked on once the queue can take two more results.
    assign proc       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    sfnc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfnc_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    sfnc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_proc    (proc),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .i_stk     (stk_stat),
        .o_stk_cmd (stk_cmd),
        .o_res     (res)
    );

    sfnc_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

FILE: tb/sv/structured_field_nesting_checker_tb.sv
module structured_field_nesting_checker_tb;

    import sfnc_pkg::*;

    localparam int RANDOM_ITEMS   = 450;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_WAIT       = 2000;
    localparam int HOLD_OFF       = 200;
    localparam int NEST_LEVELS    = 8;
    localparam logic [PADDR_W-1:0] ADDR_STREAM_LENGTH = {REG_STREAM_LENGTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_ERROR_LIMIT   = {REG_ERROR_LIMIT, 2'b00};

    typedef enum logic [2:0] {
        FR_HUNT,
        FR_LEN_HI,
        FR_LEN_LO,
        FR_HEADER,
        FR_DATA
    } t_frame_phase;

    class t_field_framing_scoreboard;
        logic [31:0]  stream_limit;
        logic [7:0]   halt_threshold;
        t_frame_phase phase;
        logic [31:0]  byte_pos;
        logic [47:0]  header;
        logic [15:0]  bytes_left;
        logic [2:0]   nest_stack [STACK_DEPTH];
        int           nest_depth;
        logic [31:0]  records;
        logic [7:0]   errors;
        logic [15:0]  pages;
        logic [15:0]  groups;
        logic [1:0]   marks;
        bit           valid;
        bit           halted;
        t_out_item    pending_results[$];
        int           failures;
        int           checked;

        function new();
            stream_limit   = STREAM_LENGTH_RESET;
            halt_threshold = ERROR_LIMIT_RESET;
            failures       = 0;
            checked        = 0;
            restart();
        endfunction

        // A finished stream leaves the framer as it was after reset, registers aside.
        function void restart();
            phase      = FR_HUNT;
            byte_pos   = '0;
            header     = '0;
            bytes_left = '0;
            nest_depth = 0;
            records    = '0;
            errors     = '0;
            pages      = '0;
            groups     = '0;
            marks      = '0;
            valid      = 1'b1;
            halted     = 1'b0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_STREAM_LENGTH) begin
                stream_limit = value;
            end else begin
                halt_threshold = value[7:0];
            end
        endfunction

        function t_out_item make_result(logic [2:0] kind, logic [23:0] id, logic [15:0] len,
                                        bit mis);
            t_out_item r;
            r.kind           = kind;
            r.record_id      = id;
            r.record_length  = len;
            r.nest_mismatch  = mis;
            r.open_depth     = 8'(nest_depth);
            r.records_seen   = records;
            r.errors_seen    = errors;
            r.pages_seen     = pages;
            r.groups_seen    = groups;
            r.document_marks = marks;
            r.stream_valid   = valid;
            r.last_result    = 1'b0;
            return r;
        endfunction

        function void count_error();
            valid = 1'b0;
            if (errors != 8'hFF) begin
                errors++;
            end
        endfunction

        function logic [2:0] nest_kind(logic [7:0] code);
            case (code)
                CAT_DOC:     return 3'd1;
                CAT_GROUP_A: return 3'd2;
                CAT_PAGE:    return 3'd3;
                CAT_AEG:     return 3'd4;
                CAT_GROUP_B: return 3'd5;
                CAT_OBJECT:  return 3'd6;
                default:     return 3'd0;
            endcase
        endfunction

        function t_out_item close_record();
            logic [23:0] id;
            logic [15:0] len;
            logic [2:0]  k;
            logic [2:0]  popped;
            bit          mis;
            id  = header[31:8];
            len = header[47:32];
            k   = nest_kind(id[7:0]);
            mis = 1'b0;
            if (id[23:16] == ID_CLASS && k != 3'd0) begin
                if (id[15:8] == TYPE_BEGIN) begin
                    // A begin that finds the stack full is still counted but not pushed.
                    if (nest_depth < STACK_DEPTH) begin
                        nest_stack[nest_depth] = k;
                        nest_depth++;
                    end
                    if (id[7:0] == CAT_DOC) marks[0] = 1'b1;
                    if (id[7:0] == CAT_PAGE && pages != 16'hFFFF) pages++;
                    if (id[7:0] == CAT_AEG && groups != 16'hFFFF) groups++;
                end else if (id[15:8] == TYPE_END) begin
                    popped = 3'd0;
                    if (id[7:0] == CAT_DOC) marks[1] = 1'b1;
                    if (nest_depth > 0) begin
                        nest_depth--;
                        popped = nest_stack[nest_depth];
                    end
                    if (popped != k) begin
                        mis   = 1'b1;
                        valid = 1'b0;
                    end
                end
            end
            if (records != 32'hFFFF_FFFF) begin
                records++;
            end
            phase = FR_HUNT;
            return make_result(K_DONE, id, len, mis);
        endfunction

        // Returns 1 when the byte was not simply dropped by the framer.
        function bit frame_byte(t_in_item item);
            logic [7:0]  b;
            logic [15:0] len;
            logic [63:0] intro_pos;
            int          sh;
            bit          took;
            t_out_item   made[$];
            b    = item.data_byte;
            took = item.end_of_stream;
            if (!halted) begin
                case (phase)
                    FR_HUNT: begin
                        if (byte_pos < stream_limit) begin
                            took = 1'b1;
                            if (b == INTRODUCER) begin
                                phase = FR_LEN_HI;
                            end else begin
                                count_error();
                                made.push_back(make_result(K_BAD_INTRO, '0, '0, 1'b0));
                                if (errors > halt_threshold) halted = 1'b1;
                            end
                        end
                    end
                    FR_LEN_HI: begin
                        took   = 1'b1;
                        header = {40'd0, b};
                        phase  = FR_LEN_LO;
                    end
                    FR_LEN_LO: begin
                        took      = 1'b1;
                        len       = {header[7:0], b};
                        intro_pos = (byte_pos >= 2) ? {32'd0, byte_pos} - 64'd2 : 64'd0;
                        header    = {32'd0, len};
                        if (len < MIN_LENGTH) begin
                            count_error();
                            phase = FR_HUNT;
                            made.push_back(make_result(K_SHORT, '0, len, 1'b0));
                        end else if (intro_pos + {48'd0, len} + 64'd1 > {32'd0, stream_limit}) begin
                            count_error();
                            phase = FR_HUNT;
                            made.push_back(make_result(K_OVERRUN, '0, len, 1'b0));
                        end else begin
                            phase      = FR_HEADER;
                            bytes_left = 16'd4;
                        end
                    end
                    FR_HEADER: begin
                        took   = 1'b1;
                        header = {header[39:0], b};
                        bytes_left--;
                        if (bytes_left == 0) begin
                            bytes_left = header[47:32] - MIN_LENGTH;
                            if (bytes_left == 0) begin
                                made.push_back(close_record());
                            end else begin
                                phase = FR_DATA;
                            end
                        end
                    end
                    default: begin
                        took = 1'b1;
                        if (bytes_left > 0) bytes_left--;
                        if (bytes_left == 0) made.push_back(close_record());
                    end
                endcase
            end
            if (byte_pos != 32'hFFFF_FFFF) begin
                byte_pos++;
            end
            if (item.end_of_stream) begin
                if (phase != FR_HUNT) begin
                    // The full record length is reported once both length bytes are in, else zero.
                    len = '0;
                    if (phase == FR_DATA) begin
                        len = header[47:32];
                    end else if (phase == FR_HEADER) begin
                        sh  = 8 * (4 - int'(bytes_left));
                        len = header[sh +: 16];
                    end
                    valid = 1'b0;
                    made.push_back(make_result(K_TRUNCATED, '0, len, 1'b0));
                end
                made.push_back(make_result(K_SUMMARY, '0, '0, 1'b0));
                restart();
            end
            if (made.size() > 0) begin
                made[made.size() - 1].last_result = 1'b1;
            end
            foreach (made[i]) begin
                pending_results.push_back(made[i]);
            end
            return took;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result of kind %0d arrived with nothing expected", got.kind);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            check_field("kind", want.kind, got.kind);
            check_field("record_id", want.record_id, got.record_id);
            check_field("record_length", want.record_length, got.record_length);
            check_field("nest_mismatch", want.nest_mismatch, got.nest_mismatch);
            check_field("open_depth", want.open_depth, got.open_depth);
            check_field("records_seen", want.records_seen, got.records_seen);
            check_field("errors_seen", want.errors_seen, got.errors_seen);
            check_field("pages_seen", want.pages_seen, got.pages_seen);
            check_field("groups_seen", want.groups_seen, got.groups_seen);
            check_field("document_marks", want.document_marks, got.document_marks);
            check_field("stream_valid", want.stream_valid, got.stream_valid);
            check_field("last_result", want.last_result, got.last_result);
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic [31:0]        prdata;
    logic               pready;

    t_field_framing_scoreboard sb = new();

    logic [7:0] stream_q[$];
    logic [7:0] open_codes[$];
    int         in_idle_mode     = 0;
    int         out_idle_mode    = 0;
    int         long_hold_cycles = 0;
    int         counted_bytes    = 0;
    int         total_bytes      = 0;
    int         stream_count     = 0;
    int         setting_count    = 0;

    structured_field_nesting_checker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    // Result side: one stall draw per transfer, plus the long hold-off on request.
    initial begin : result_side
        int n;
        forever begin
            if (long_hold_cycles > 0) begin
                n = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                n = draw_wait(out_idle_mode);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(addr[2], value);
        @(posedge i_clk);
    endtask

    task automatic wait_results();
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic wait_quiet();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eos, input int gap);
        t_in_item item;
        item.data_byte     = b;
        item.end_of_stream = eos;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        total_bytes++;
        if (sb.frame_byte(item)) counted_bytes++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The last byte of the queue carries the end-of-stream mark.
    task automatic send_stream(input bit pause_midway);
        int pause_at;
        pause_at = (pause_midway && stream_q.size() > 1) ?
                   $urandom_range(1, stream_q.size() - 1) : -1;
        foreach (stream_q[i]) begin
            if (i == pause_at) begin
                i_in_valid <= 1'b0;
                wait_results();
            end
            send_byte(stream_q[i], i == stream_q.size() - 1, draw_wait(in_idle_mode));
        end
        i_in_valid <= 1'b0;
        stream_count++;
    endtask

    task automatic set_registers(input logic [31:0] limit, input logic [7:0] max_errors);
        write_reg(ADDR_STREAM_LENGTH, limit);
        write_reg(ADDR_ERROR_LIMIT, {24'd0, max_errors});
        setting_count++;
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0] codes[6];
        codes = '{CAT_DOC, CAT_GROUP_A, CAT_PAGE, CAT_AEG, CAT_GROUP_B, CAT_OBJECT};
        return codes[$urandom_range(0, 5)];
    endfunction

    function automatic void add_record(input logic [23:0] id, input logic [15:0] len);
        stream_q.push_back(INTRODUCER);
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
        stream_q.push_back(id[23:16]);
        stream_q.push_back(id[15:8]);
        stream_q.push_back(id[7:0]);
        stream_q.push_back(8'($urandom_range(0, 255)));
        for (int i = MIN_LENGTH; i < len; i++) begin
            stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Mostly nested begin/end records; some noise, short and oversized headers.
    function automatic void build_random_stream(input int n_parts);
        int          pick;
        logic [7:0]  code;
        logic [15:0] len;
        stream_q.delete();
        open_codes.delete();
        repeat (n_parts) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(6, 40))
                                               : 16'($urandom_range(6, 12));
            if (pick < 8) begin
                stream_q.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 13) begin
                stream_q.push_back(INTRODUCER);
                stream_q.push_back(8'h00);
                stream_q.push_back(8'($urandom_range(0, 5)));
            end else if (pick < 17) begin
                stream_q.push_back(INTRODUCER);
                stream_q.push_back(8'($urandom_range(1, 255)));
                stream_q.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 55) begin
                code = pick_code();
                open_codes.push_back(code);
                add_record({ID_CLASS, TYPE_BEGIN, code}, len);
            end else if (pick < 85) begin
                if (open_codes.size() > 0 && $urandom_range(0, 7) != 0) begin
                    code = open_codes.pop_back();
                end else begin
                    code = pick_code();
                end
                add_record({ID_CLASS, TYPE_END, code}, len);
            end else if (pick < 93) begin
                add_record({ID_CLASS, 16'($urandom)}, len);
            end else begin
                add_record(24'($urandom), len);
            end
        end
    endfunction

    task automatic run_random_stream(input int n_parts);
        logic [31:0] limit;
        logic [7:0]  max_errors;
        int          cut;
        int          size;
        build_random_stream(n_parts);
        if (stream_q.size() > 2 && $urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
        size = stream_q.size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: limit = 32'(size);
            6, 7:             limit = 32'(size - $urandom_range(0, size / 2));
            8:                limit = 32'hFFFF_FFFF;
            default:          limit = 32'd0;
        endcase
        case ($urandom_range(0, 3))
            0:       max_errors = 8'd0;
            1:       max_errors = 8'd255;
            default: max_errors = 8'($urandom_range(1, 12));
        endcase
        set_registers(limit, max_errors);
        in_idle_mode  = $urandom_range(0, 2);
        out_idle_mode = $urandom_range(0, 2);
        send_stream($urandom_range(0, 5) == 0);
        wait_quiet();
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset stream length of zero every hunted byte is dropped.
        stream_q = '{INTRODUCER, 8'hFF};
        send_stream(1'b0);
        wait_quiet();

        // Two bad introducers pass an error limit of one and halt the framer.
        set_registers(32'd32, 8'd1);
        stream_q = '{8'h00, 8'hFF, INTRODUCER, INTRODUCER};
        send_stream(1'b0);
        wait_quiet();

        // End on an empty stack, short and overrunning lengths, then an end inside data.
        set_registers(32'd32, 8'd0);
        stream_q = '{INTRODUCER, 8'h00, 8'h06, ID_CLASS, TYPE_END, CAT_DOC, 8'h00,
                     INTRODUCER, 8'h00, 8'h03,
                     INTRODUCER, 8'hFF, 8'hFF,
                     INTRODUCER, 8'h00, 8'h08, ID_CLASS, TYPE_BEGIN, CAT_PAGE, 8'h00, 8'hAB};
        send_stream(1'b0);
        wait_quiet();

        // Results pile up behind a long hold-off while bad introducers keep coming.
        set_registers(32'hFFFF_FFFF, 8'd255);
        stream_q.delete();
        repeat (60) stream_q.push_back(8'($urandom_range(0, 255)) ^ 8'h01 | 8'h01 ^ 8'h01);
        foreach (stream_q[i]) begin
            if (stream_q[i] == INTRODUCER) stream_q[i] = ~INTRODUCER;
        end
        in_idle_mode     = 0;
        out_idle_mode    = 1;
        long_hold_cycles = HOLD_OFF;
        send_stream(1'b0);
        wait_quiet();

        // Nest a few levels deep, then unwind part of the way.
        set_registers(32'hFFFF_FFFF, 8'd10);
        stream_q.delete();
        open_codes.delete();
        repeat (NEST_LEVELS) begin
            open_codes.push_back(pick_code());
            add_record({ID_CLASS, TYPE_BEGIN, open_codes[open_codes.size() - 1]}, MIN_LENGTH);
        end
        repeat (4) add_record({ID_CLASS, TYPE_END, open_codes.pop_back()}, MIN_LENGTH);
        in_idle_mode  = $urandom_range(0, 2);
        out_idle_mode = $urandom_range(0, 2);
        send_stream(1'b1);
        wait_quiet();

        while (counted_bytes < RANDOM_ITEMS) begin
            run_random_stream($urandom_range(1, 12));
        end

        for (int c = 0; c < END_WAIT && sb.pending_results.size() != 0; c++) begin
            @(posedge i_clk);
        end
        if (sb.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.failures++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d streams under %0d register settings.",
                 total_bytes, stream_count, setting_count);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.failures);
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
